FILE: src/cptri_pkg.sv
// Shared widths, types, region codes and helpers of the closest-point-on-triangle block.
`default_nettype none
package cptri_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int WBITS     = 16;

	// Three products of two coordinate differences, summed.
	localparam int SUM_W  = 2 * (COORD_W + 1) + 2;
	localparam int DOT_W  = SUM_W - FRAC_BITS;
	localparam int PROD_W = 2 * DOT_W;
	localparam int WIDE_W = PROD_W + 1;
	localparam int LO_W   = 32;
	localparam int HI_W   = DOT_W - LO_W;

	localparam int MUL_LAT    = 4;
	localparam int DIV_STAGES = WBITS;
	localparam int LATENCY    = 3 + MUL_LAT + 4 + DIV_STAGES + 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0]   diff_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic [PROD_W-1:0]         udiv_t;
	typedef logic [WBITS:0]            weight_t;
	typedef logic [2:0]                region_t;

	localparam weight_t WONE = {1'b1, {WBITS{1'b0}}};

	localparam region_t REG_A   = 3'd0;
	localparam region_t REG_B   = 3'd1;
	localparam region_t REG_AB  = 3'd2;
	localparam region_t REG_C   = 3'd3;
	localparam region_t REG_AC  = 3'd4;
	localparam region_t REG_BC  = 3'd5;
	localparam region_t REG_IN  = 3'd6;
	localparam region_t REG_DEG = 3'd7;

	typedef struct packed {
		coord_t [2:0] a;
		coord_t [2:0] b;
		coord_t [2:0] c;
		diff_t [2:0]  ab;
		diff_t [2:0]  ac;
		diff_t [2:0]  bc;
	} geom_t;

endpackage
`default_nettype wire

FILE: src/closest_point_on_triangle_unit.sv
// Top level: pipelined closest point on a triangle with Voronoi region classification.
`default_nettype none
// Usage:
// Drive a query point and the three corners a, b, c (signed Q16.16) and pulse start.
// A beat is taken at every rising edge where start is high and busy is low; busy stays
// low, so a new query can enter on every clock cycle.
// Each beat comes back in order: done is high for one cycle and the
// closest point, the three barycentric weights (Q0.16, 65536 is one) and the region code
// sit on the result ports for that cycle only. The receiver cannot stall the block.
// Throughput is one query per cycle. The latency is set by the dot products (3 stages),
// the four-stage 52x52 cross-term multipliers, four stages of region selection and
// divisor setup, the 16-stage weight dividers (one quotient bit per stage) and two
// stages that blend the corners back into a point.
// Reset clears only the valid bits of the pipeline: queries in flight are dropped and
// no done pulse appears for them.
module closest_point_on_triangle_unit import cptri_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	output logic                      done,
	input  wire logic signed [31:0]   query_x,
	input  wire logic signed [31:0]   query_y,
	input  wire logic signed [31:0]   query_z,
	input  wire logic signed [31:0]   corner_a_x,
	input  wire logic signed [31:0]   corner_a_y,
	input  wire logic signed [31:0]   corner_a_z,
	input  wire logic signed [31:0]   corner_b_x,
	input  wire logic signed [31:0]   corner_b_y,
	input  wire logic signed [31:0]   corner_b_z,
	input  wire logic signed [31:0]   corner_c_x,
	input  wire logic signed [31:0]   corner_c_y,
	input  wire logic signed [31:0]   corner_c_z,
	output logic signed [31:0]        near_x,
	output logic signed [31:0]        near_y,
	output logic signed [31:0]        near_z,
	output logic [16:0]               weight_a,
	output logic [16:0]               weight_b,
	output logic [16:0]               weight_c,
	output logic [2:0]                region
);

	localparam int BL_W  = COORD_W + WBITS + 3;
	localparam int ACC_W = BL_W + 1;
	localparam int T_W   = ACC_W - WBITS + 1;
	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (WBITS - 1);

	typedef logic signed [2*COORD_W+1:0] pp_t;
	typedef logic signed [BL_W-1:0]      bl_t;

	typedef struct packed {
		logic    fix;
		weight_t fixv;
		udiv_t   num;
		udiv_t   den;
	} lane_t;

	typedef struct packed {
		geom_t              g;
		region_t            rg;
		logic [1:0]         fix;
		weight_t [1:0]      fixv;
	} side_t;

	function automatic diff_t sub_c(input coord_t x, input coord_t y);
		return (COORD_W+1)'(x) - (COORD_W+1)'(y);
	endfunction

	function automatic wide_t wx(input dot_t d);
		return WIDE_W'(d);
	endfunction

	function automatic logic le0(input wide_t v);
		return v[WIDE_W-1] || (v == '0);
	endfunction

	// A ratio outside the open interval is settled here; the rest goes to the divider.
	function automatic lane_t setup(input wide_t n, input wide_t d);
		lane_t r;
		wide_t dd;
		dd = le0(d) ? WIDE_W'(1) : d;
		r.fix  = 1'b1;
		r.fixv = '0;
		r.num  = '0;
		r.den  = dd[PROD_W-1:0];
		if (le0(n)) begin
			r.fixv = '0;
		end else if (!(n < dd)) begin
			r.fixv = WONE;
		end else begin
			r.fix = 1'b0;
			r.num = n[PROD_W-1:0];
		end
		return r;
	endfunction

	function automatic coord_t sat_c(input logic signed [T_W-1:0] t);
		if (t[T_W-1:COORD_W-1] == '0 || t[T_W-1:COORD_W-1] == {(T_W-COORD_W+1){1'b1}}) begin
			return t[COORD_W-1:0];
		end
		return t[T_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	coord_t [2:0] qv, av, bv, cv;
	logic         accept;

	assign qv = {query_z, query_y, query_x};
	assign av = {corner_a_z, corner_a_y, corner_a_x};
	assign bv = {corner_b_z, corner_b_y, corner_b_x};
	assign cv = {corner_c_z, corner_c_y, corner_c_x};
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Valid bits.
	logic                  vld_s1, vld_s2, vld_s3, vld_s8, vld_s9, vld_s10, vld_s11;
	logic                  vld_s28, vld_s29;
	logic [MUL_LAT-1:0]    mvld_s;
	logic [DIV_STAGES-1:0] dvld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			mvld_s  <= '0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			dvld_s  <= '0;
			vld_s28 <= 1'b0;
			vld_s29 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			mvld_s  <= {mvld_s[MUL_LAT-2:0], vld_s3};
			vld_s8  <= mvld_s[MUL_LAT-1];
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			dvld_s  <= {dvld_s[DIV_STAGES-2:0], vld_s11};
			vld_s28 <= dvld_s[DIV_STAGES-1];
			vld_s29 <= vld_s28;
		end
	end

	// Stage 1: corner differences.
	geom_t        geom_s1;
	diff_t [2:0]  ap_s1, bp_s1, cp_s1;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			geom_s1.a[k]  <= av[k];
			geom_s1.b[k]  <= bv[k];
			geom_s1.c[k]  <= cv[k];
			geom_s1.ab[k] <= sub_c(bv[k], av[k]);
			geom_s1.ac[k] <= sub_c(cv[k], av[k]);
			geom_s1.bc[k] <= sub_c(cv[k], bv[k]);
			ap_s1[k]      <= sub_c(qv[k], av[k]);
			bp_s1[k]      <= sub_c(qv[k], bv[k]);
			cp_s1[k]      <= sub_c(qv[k], cv[k]);
		end
	end

	// Stage 2: the eighteen coordinate products.
	geom_t     geom_s2;
	pp_t [2:0] prod_s2 [1:6];

	always_ff @(posedge clk) begin
		geom_s2 <= geom_s1;
		for (int k = 0; k < 3; k++) begin
			prod_s2[1][k] <= $signed(geom_s1.ab[k]) * $signed(ap_s1[k]);
			prod_s2[2][k] <= $signed(geom_s1.ac[k]) * $signed(ap_s1[k]);
			prod_s2[3][k] <= $signed(geom_s1.ab[k]) * $signed(bp_s1[k]);
			prod_s2[4][k] <= $signed(geom_s1.ac[k]) * $signed(bp_s1[k]);
			prod_s2[5][k] <= $signed(geom_s1.ab[k]) * $signed(cp_s1[k]);
			prod_s2[6][k] <= $signed(geom_s1.ac[k]) * $signed(cp_s1[k]);
		end
	end

	// Stage 3: dot products, floored by the fraction width. They always fit DOT_W bits.
	geom_t geom_s3;
	dot_t  dot_c  [1:6];
	dot_t  dot_s3 [1:6];

	always_comb begin
		logic signed [SUM_W-1:0] sum;
		for (int j = 1; j <= 6; j++) begin
			sum = SUM_W'($signed(prod_s2[j][0])) + SUM_W'($signed(prod_s2[j][1]))
				+ SUM_W'($signed(prod_s2[j][2]));
			dot_c[j] = DOT_W'(sum >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		geom_s3 <= geom_s2;
		for (int j = 1; j <= 6; j++) begin
			dot_s3[j] <= dot_c[j];
		end
	end

	// Cross terms of the dot products through the multipliers.
	dot_t  mx [0:5];
	dot_t  my [0:5];
	wide_t mp [0:5];

	assign mx[0] = dot_s3[1];
	assign my[0] = dot_s3[4];
	assign mx[1] = dot_s3[3];
	assign my[1] = dot_s3[2];
	assign mx[2] = dot_s3[5];
	assign my[2] = dot_s3[2];
	assign mx[3] = dot_s3[1];
	assign my[3] = dot_s3[6];
	assign mx[4] = dot_s3[3];
	assign my[4] = dot_s3[6];
	assign mx[5] = dot_s3[5];
	assign my[5] = dot_s3[4];

	for (genvar i = 0; i < 6; i++) begin : g_mul
		cptri_mul u_mul (
			.clk (clk),
			.x   (mx[i]),
			.y   (my[i]),
			.p   (mp[i])
		);
	end

	geom_t gm_s [0:MUL_LAT-1];
	dot_t  dm_s [0:MUL_LAT-1][1:6];

	always_ff @(posedge clk) begin
		gm_s[0] <= geom_s3;
		for (int j = 1; j <= 6; j++) begin
			dm_s[0][j] <= dot_s3[j];
		end
		for (int s = 1; s < MUL_LAT; s++) begin
			gm_s[s] <= gm_s[s-1];
			for (int j = 1; j <= 6; j++) begin
				dm_s[s][j] <= dm_s[s-1][j];
			end
		end
	end

	// Stage 8: barycentric cross terms.
	geom_t geom_s8;
	dot_t  dot_s8 [1:6];
	wide_t va_s8, vb_s8, vc_s8;

	always_ff @(posedge clk) begin
		geom_s8 <= gm_s[MUL_LAT-1];
		for (int j = 1; j <= 6; j++) begin
			dot_s8[j] <= dm_s[MUL_LAT-1][j];
		end
		vc_s8 <= mp[0] - mp[1];
		vb_s8 <= mp[2] - mp[3];
		va_s8 <= mp[4] - mp[5];
	end

	// Stage 9: region tests, interior denominator and edge fractions.
	geom_t      geom_s9;
	logic [5:0] hit_s9;
	wide_t      den_s9, vbq_s9, vcq_s9;
	wide_t      abn_s9, abd_s9, acn_s9, acd_s9, bcn_s9, bcd_s9;

	always_ff @(posedge clk) begin
		geom_s9   <= geom_s8;
		hit_s9[0] <= (dot_s8[1] <= 0) && (dot_s8[2] <= 0);
		hit_s9[1] <= (dot_s8[3] >= 0) && (dot_s8[4] <= dot_s8[3]);
		hit_s9[2] <= le0(vc_s8) && (dot_s8[1] >= 0) && (dot_s8[3] <= 0);
		hit_s9[3] <= (dot_s8[6] >= 0) && (dot_s8[5] <= dot_s8[6]);
		hit_s9[4] <= le0(vb_s8) && (dot_s8[2] >= 0) && (dot_s8[6] <= 0);
		hit_s9[5] <= le0(va_s8) && (dot_s8[4] >= dot_s8[3]) && (dot_s8[5] >= dot_s8[6]);
		den_s9    <= (va_s8 >>> 2) + (vb_s8 >>> 2) + (vc_s8 >>> 2);
		vbq_s9    <= vb_s8 >>> 2;
		vcq_s9    <= vc_s8 >>> 2;
		abn_s9    <= wx(dot_s8[1]);
		abd_s9    <= wx(dot_s8[1]) - wx(dot_s8[3]);
		acn_s9    <= wx(dot_s8[2]);
		acd_s9    <= wx(dot_s8[2]) - wx(dot_s8[6]);
		bcn_s9    <= wx(dot_s8[4]) - wx(dot_s8[3]);
		bcd_s9    <= wx(dot_s8[4]) - wx(dot_s8[3]) + wx(dot_s8[5]) - wx(dot_s8[6]);
	end

	// Stage 10: the first region test that holds wins.
	geom_t   geom_s10;
	region_t region_c, region_s10;
	wide_t   l0n_c, l0d_c, l1n_c, l1d_c;
	wide_t   l0n_s10, l0d_s10, l1n_s10, l1d_s10;

	always_comb begin
		region_c = REG_IN;
		l0n_c    = '0;
		l0d_c    = WIDE_W'(1);
		l1n_c    = '0;
		l1d_c    = WIDE_W'(1);
		if (hit_s9[0]) begin
			region_c = REG_A;
		end else if (hit_s9[1]) begin
			region_c = REG_B;
		end else if (hit_s9[2]) begin
			region_c = REG_AB;
			l0n_c    = abn_s9;
			l0d_c    = abd_s9;
		end else if (hit_s9[3]) begin
			region_c = REG_C;
		end else if (hit_s9[4]) begin
			region_c = REG_AC;
			l0n_c    = acn_s9;
			l0d_c    = acd_s9;
		end else if (hit_s9[5]) begin
			region_c = REG_BC;
			l0n_c    = bcn_s9;
			l0d_c    = bcd_s9;
		end else if (le0(den_s9)) begin
			region_c = REG_DEG;
		end else begin
			region_c = REG_IN;
			l0n_c    = vbq_s9;
			l0d_c    = den_s9;
			l1n_c    = vcq_s9;
			l1d_c    = den_s9;
		end
	end

	always_ff @(posedge clk) begin
		geom_s10   <= geom_s9;
		region_s10 <= region_c;
		l0n_s10    <= l0n_c;
		l0d_s10    <= l0d_c;
		l1n_s10    <= l1n_c;
		l1d_s10    <= l1d_c;
	end

	// Stage 11: divisor clamp and the trivial quotients.
	geom_t   geom_s11;
	region_t region_s11;
	lane_t   lane_s11 [0:1];

	always_ff @(posedge clk) begin
		geom_s11    <= geom_s10;
		region_s11  <= region_s10;
		lane_s11[0] <= setup(l0n_s10, l0d_s10);
		lane_s11[1] <= setup(l1n_s10, l1d_s10);
	end

	logic [WBITS-1:0] quo [0:1];

	for (genvar i = 0; i < 2; i++) begin : g_div
		cptri_div u_div (
			.clk (clk),
			.num (lane_s11[i].num),
			.den (lane_s11[i].den),
			.quo (quo[i])
		);
	end

	side_t sd_s [0:DIV_STAGES-1];

	always_ff @(posedge clk) begin
		sd_s[0].g       <= geom_s11;
		sd_s[0].rg      <= region_s11;
		sd_s[0].fix     <= {lane_s11[1].fix, lane_s11[0].fix};
		sd_s[0].fixv[0] <= lane_s11[0].fixv;
		sd_s[0].fixv[1] <= lane_s11[1].fixv;
		for (int s = 1; s < DIV_STAGES; s++) begin
			sd_s[s] <= sd_s[s-1];
		end
	end

	// Stage 28: pick base, directions and weights, and scale the directions.
	side_t        sd;
	weight_t      k0, k1;
	logic [WBITS+1:0] ksum;
	coord_t [2:0] base_c;
	diff_t [2:0]  dir1_c, dir2_c;
	weight_t      wa_c, wb_c, wc_c;

	assign sd   = sd_s[DIV_STAGES-1];
	assign k0   = sd.fix[0] ? sd.fixv[0] : {1'b0, quo[0]};
	assign k1   = sd.fix[1] ? sd.fixv[1] : {1'b0, quo[1]};
	assign ksum = {1'b0, k0} + {1'b0, k1};

	always_comb begin
		base_c = sd.g.a;
		dir1_c = '0;
		dir2_c = '0;
		wa_c   = WONE;
		wb_c   = '0;
		wc_c   = '0;
		case (sd.rg)
			REG_A, REG_DEG: begin
				base_c = sd.g.a;
			end
			REG_B: begin
				base_c = sd.g.b;
				wa_c   = '0;
				wb_c   = WONE;
			end
			REG_C: begin
				base_c = sd.g.c;
				wa_c   = '0;
				wc_c   = WONE;
			end
			REG_AB: begin
				dir1_c = sd.g.ab;
				wa_c   = WONE - k0;
				wb_c   = k0;
			end
			REG_AC: begin
				dir1_c = sd.g.ac;
				wa_c   = WONE - k0;
				wc_c   = k0;
			end
			REG_BC: begin
				base_c = sd.g.b;
				dir1_c = sd.g.bc;
				wa_c   = '0;
				wb_c   = WONE - k0;
				wc_c   = k0;
			end
			REG_IN: begin
				dir1_c = sd.g.ab;
				dir2_c = sd.g.ac;
				wa_c   = (ksum >= {1'b0, WONE}) ? '0 : WONE - k0 - k1;
				wb_c   = k0;
				wc_c   = k1;
			end
			default: begin
				base_c = sd.g.a;
			end
		endcase
	end

	coord_t [2:0] base_s28;
	bl_t          pr1_s28 [0:2];
	bl_t          pr2_s28 [0:2];
	weight_t      wa_s28, wb_s28, wc_s28;
	region_t      region_s28;

	always_ff @(posedge clk) begin
		base_s28   <= base_c;
		wa_s28     <= wa_c;
		wb_s28     <= wb_c;
		wc_s28     <= wc_c;
		region_s28 <= sd.rg;
		for (int k = 0; k < 3; k++) begin
			pr1_s28[k] <= $signed(dir1_c[k]) * $signed({1'b0, k0});
			pr2_s28[k] <= $signed(dir2_c[k]) * $signed({1'b0, k1});
		end
	end

	// Stage 29: round half up, add the base corner and saturate.
	coord_t [2:0] near_c, near_s29;
	weight_t      wa_s29, wb_s29, wc_s29;
	region_t      region_s29;

	always_comb begin
		logic signed [ACC_W-1:0] acc;
		logic signed [T_W-1:0]   t;
		for (int k = 0; k < 3; k++) begin
			acc = ACC_W'(pr1_s28[k]) + ACC_W'(pr2_s28[k]) + ROUND;
			t   = T_W'(acc >>> WBITS) + T_W'(base_s28[k]);
			near_c[k] = sat_c(t);
		end
	end

	always_ff @(posedge clk) begin
		near_s29   <= near_c;
		wa_s29     <= wa_s28;
		wb_s29     <= wb_s28;
		wc_s29     <= wc_s28;
		region_s29 <= region_s28;
	end

	assign done     = vld_s29;
	assign near_x   = near_s29[0];
	assign near_y   = near_s29[1];
	assign near_z   = near_s29[2];
	assign weight_a = wa_s29;
	assign weight_b = wb_s29;
	assign weight_c = wc_s29;
	assign region   = region_s29;

endmodule
`default_nettype wire

FILE: src/cptri_mul.sv
// Four-stage signed multiplier for two dot products, built from partial products of 32-bit low and 20-bit high halves.
`default_nettype none
module cptri_mul import cptri_pkg::*; (
	input  logic  clk,
	input  dot_t  x,
	input  dot_t  y,
	output wide_t p
);

	logic              neg_s1, neg_s2, neg_s3;
	logic [DOT_W-1:0]  xm_s1, ym_s1;
	logic [2*LO_W-1:0] ll_s2;
	logic [DOT_W-1:0]  lh_s2, hl_s2;
	logic [2*HI_W-1:0] hh_s2;
	logic [PROD_W-1:0] mag_s3;
	wide_t             p_s4;

	always_ff @(posedge clk) begin
		neg_s1 <= x[DOT_W-1] ^ y[DOT_W-1];
		xm_s1  <= x[DOT_W-1] ? DOT_W'(-x) : x;
		ym_s1  <= y[DOT_W-1] ? DOT_W'(-y) : y;

		neg_s2 <= neg_s1;
		ll_s2  <= xm_s1[LO_W-1:0] * ym_s1[LO_W-1:0];
		lh_s2  <= xm_s1[LO_W-1:0] * ym_s1[DOT_W-1:LO_W];
		hl_s2  <= xm_s1[DOT_W-1:LO_W] * ym_s1[LO_W-1:0];
		hh_s2  <= xm_s1[DOT_W-1:LO_W] * ym_s1[DOT_W-1:LO_W];

		neg_s3 <= neg_s2;
		mag_s3 <= {hh_s2, ll_s2} + (PROD_W'(lh_s2) << LO_W) + (PROD_W'(hl_s2) << LO_W);

		p_s4 <= neg_s3 ? -$signed({1'b0, mag_s3}) : $signed({1'b0, mag_s3});
	end

	assign p = p_s4;

endmodule
`default_nettype wire

FILE: src/cptri_div.sv
// Pipelined restoring divider: one quotient bit of a positive proper fraction per stage.
`default_nettype none
module cptri_div import cptri_pkg::*; (
	input  logic             clk,
	input  udiv_t            num,
	input  udiv_t            den,
	output logic [WBITS-1:0] quo
);

	udiv_t            rem_s [0:DIV_STAGES];
	udiv_t            den_s [0:DIV_STAGES];
	logic [WBITS-1:0] quo_s [0:DIV_STAGES];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	// The remainder stays below the divisor, so doubling it never loses the top bit.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
		udiv_t shl;
		logic  ge;

		assign shl = {rem_s[k][PROD_W-2:0], 1'b0};
		assign ge  = shl >= den_s[k];

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? shl - den_s[k] : shl;
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= {quo_s[k][WBITS-2:0], ge};
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule
`default_nettype wire

FILE: src/cptri_checker.sv
// Port-level checker for the closest-point-on-triangle unit, bound to the top level.
`default_nettype none
module cptri_checker import cptri_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic signed [31:0] corner_a_x,
	input wire logic signed [31:0] corner_b_y,
	input wire logic signed [31:0] near_x,
	input wire logic signed [31:0] near_y,
	input wire logic [16:0]        weight_a,
	input wire logic [16:0]        weight_b,
	input wire logic [16:0]        weight_c,
	input wire logic [2:0]         region
);

	// Every accepted beat returns after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted beat did not return on time");

	// A result only appears for a beat taken the fixed latency earlier.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching beat");

	// A corner-a or degenerate result carries the x coordinate of corner a and all weight on a.
	a_corner_a: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (region == REG_A || region == REG_DEG)) |->
		(near_x == $past(corner_a_x, LATENCY) && weight_a == WONE
		&& weight_b == '0 && weight_c == '0))
		else $error("corner a result is inconsistent");

	// A corner-b result carries the y coordinate of corner b and all weight on b.
	a_corner_b: assert property (@(posedge clk) disable iff (!arst_n)
		(done && region == REG_B) |->
		(near_y == $past(corner_b_y, LATENCY) && weight_b == WONE))
		else $error("corner b result is inconsistent");

	// Weights on edge ab add up to one and weight c is zero.
	a_edge_ab: assert property (@(posedge clk) disable iff (!arst_n)
		(done && region == REG_AB) |->
		(weight_c == '0 && ({1'b0, weight_a} + {1'b0, weight_b}) == {1'b0, WONE}))
		else $error("edge ab weights do not add up to one");

endmodule

bind closest_point_on_triangle_unit cptri_checker u_cptri_checker (.*);
`default_nettype wire
